// ----- hdl/vgda_pkg.sv -----
package vgda_pkg;

    localparam int MAX_X      = 64;
    localparam int MAX_Y      = 64;
    localparam int MAX_Z      = 64;
    localparam int SCORE_BITS = 16;

    localparam int CELL_COUNT = MAX_X * MAX_Y * MAX_Z;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int X_W        = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int Y_W        = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int Z_W        = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int MAX_D      = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                                : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
    localparam int DIM_E_W    = $clog2(MAX_D + 1);

    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 6;
    localparam int VAL_W      = 16;
    localparam int LAYER_W    = 8;
    localparam int MEAN_W     = 32;
    localparam int SUM_W      = 64;
    localparam int SQ_W       = 2 * SCORE_BITS;
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int CMP_W      = (POS_W > DIM_E_W) ? POS_W + 1 : DIM_E_W + 1;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

    localparam longint S_HI   = (64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1;
    localparam longint S_LO   = -S_HI - 64'sd1;
    localparam longint O_HI   = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    localparam longint O_LO   = -O_HI - 64'sd1;

    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [DIM_E_W-1:0]           t_edim;
    typedef logic [SUM_W-1:0]             t_sum;
    typedef logic [CNT_W-1:0]             t_cnt;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_COLUMN = 2'd1,
        MODE_MEAN   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_X = 2'd0,
        CFG_DIM_Y = 2'd1,
        CFG_DIM_Z = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_MS,
        ST_DRAIN,
        ST_DIV,
        ST_CLR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_score data;
    } t_mem_wr;

    function automatic t_edim clamp_dim(input logic [CFG_W-1:0] v, input int limit);
        t_edim r;
        if (v == '0) begin
            r = t_edim'(1);
        end else if (int'(v) > limit) begin
            r = t_edim'(limit);
        end else begin
            r = t_edim'(v);
        end
        return r;
    endfunction

    function automatic t_addr cell_addr(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                        input logic [Z_W-1:0] z);
        return t_addr'(x) + t_addr'(MAX_X) * t_addr'(y)
             + t_addr'(MAX_X * MAX_Y) * t_addr'(z);
    endfunction

    function automatic t_score sat_in(input logic signed [VAL_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > S_HI) w = S_HI;
        if (w < S_LO) w = S_LO;
        return w[SCORE_BITS-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_out(input t_score s);
        logic signed [63:0] w;
        w = 64'(s);
        if (w > O_HI) w = O_HI;
        if (w < O_LO) w = O_LO;
        return w[VAL_W-1:0];
    endfunction

endpackage

// ----- hdl/vgda_mem.sv -----
module vgda_mem (
    input  logic             i_clk,
    input  vgda_pkg::t_mem_wr i_wr,
    input  vgda_pkg::t_addr  i_raddr,
    output vgda_pkg::t_score o_rdata
);
    import vgda_pkg::*;

    t_score r_mem [CELL_COUNT];
    t_score r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/vgda_div.sv -----
module vgda_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  vgda_pkg::t_sum i_dividend,
    input  vgda_pkg::t_cnt i_divisor,
    output logic           o_done,
    output vgda_pkg::t_sum o_quotient
);
    import vgda_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    t_sum              r_dvd;
    t_sum              r_quo;
    t_cnt              r_rem;
    t_cnt              r_div;

    logic [CNT_W:0] trial;
    logic           ge;
    t_cnt           n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[SUM_W-1]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? CNT_W'(trial - {1'b0, r_div}) : CNT_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                r_busy <= r_step != STEP_W'(SUM_W - 1);
                r_done <= r_step == STEP_W'(SUM_W - 1);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hdl/voxel_grid_depth_argmax.sv -----
// Voxel score grid with depth argmax. One item at a time, one result beat per item.
// A column query makes one stored layer read per cycle from the grid memory; a mean square
// query makes one cell read, squared and accumulated per cycle, then a 64-step bit-serial
// divide by the cell count. A clear (mode 3) walks the whole grid of CELL_COUNT cells, one
// cell per cycle. The same clearing pass runs after reset and after each write to dim_x,
// dim_y or dim_z; input is not accepted until it ends, while configuration writes are
// always taken. A finished result waits in the output register.
module voxel_grid_depth_argmax (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_mode,
    input  logic [vgda_pkg::POS_W-1:0]          i_pos_x,
    input  logic [vgda_pkg::POS_W-1:0]          i_pos_y,
    input  logic [vgda_pkg::POS_W-1:0]          i_pos_z,
    input  logic signed [vgda_pkg::VAL_W-1:0]   i_voxel_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [vgda_pkg::VAL_W-1:0]   o_max_score,
    output logic [vgda_pkg::LAYER_W-1:0]        o_max_layer,
    output logic [vgda_pkg::MEAN_W-1:0]         o_mean_square,
    output logic                                o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vgda_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vgda_pkg::CFG_W-1:0]          i_cfg_data
);
    import vgda_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode;
    logic   r_status;

    logic [CFG_W-1:0] r_dim_x, r_dim_y, r_dim_z;
    t_edim            dx, dy, dz;

    logic [X_W-1:0] r_px, r_wx;
    logic [Y_W-1:0] r_py, r_wy;
    logic [Z_W-1:0] r_wz, r_rd_z, r_at;

    logic            r_rd_vld;
    logic            r_sq_vld;
    logic [SQ_W-1:0] r_sq;
    t_sum            r_sum;
    t_score          r_best;

    logic  r_clearing;
    t_addr r_clr_addr;

    logic                       r_o_valid;
    logic signed [VAL_W-1:0]    r_o_score;
    logic [LAYER_W-1:0]         r_o_layer;
    logic [MEAN_W-1:0]          r_o_mean;
    logic                       r_o_status;

    logic    in_acc, cfg_acc, cfg_hit, clr_start;
    logic    bad_xy, bad_z;
    logic    last_x, last_y, last_z;
    logic    issue, drained, div_start, div_done, out_load;
    t_mode   in_mode;
    t_addr   rd_addr;
    t_mem_wr wr;
    t_score  rdata;
    t_sum    quotient;
    t_cnt    count;

    logic [SCORE_BITS-1:0] mag;
    logic [SUM_W:0]        acc;

    vgda_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    vgda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        dx      = clamp_dim(r_dim_x, MAX_X);
        dy      = clamp_dim(r_dim_y, MAX_Y);
        dz      = clamp_dim(r_dim_z, MAX_Z);
        count   = CNT_W'(dx) * CNT_W'(dy) * CNT_W'(dz);
        in_mode = t_mode'(i_mode);
        in_acc  = i_in_valid && o_in_ready;
        cfg_acc = i_cfg_valid && o_cfg_ready;
        bad_xy  = (CMP_W'(i_pos_x) >= CMP_W'(dx)) || (CMP_W'(i_pos_y) >= CMP_W'(dy));
        bad_z   = CMP_W'(i_pos_z) >= CMP_W'(dz);
        last_x  = t_edim'(r_wx) == dx - t_edim'(1);
        last_y  = t_edim'(r_wy) == dy - t_edim'(1);
        last_z  = t_edim'(r_wz) == dz - t_edim'(1);
        drained = !r_rd_vld && !r_sq_vld;
        case (t_cfg_idx'(i_cfg_index))
            CFG_DIM_X, CFG_DIM_Y, CFG_DIM_Z: cfg_hit = 1'b1;
            default:                         cfg_hit = 1'b0;
        endcase
        clr_start = (cfg_acc && cfg_hit) || (in_acc && in_mode == MODE_CLEAR);
        mag = rdata[SCORE_BITS-1] ? SCORE_BITS'(~rdata + 1'b1) : SCORE_BITS'(rdata);
        acc = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_mode)
                        MODE_COLUMN: n_state = bad_xy ? ST_OUT : ST_COL;
                        MODE_MEAN:   n_state = ST_MS;
                        MODE_CLEAR:  n_state = ST_CLR;
                        default:     n_state = ST_OUT;
                    endcase
                end
            end
            ST_COL: begin
                if (last_z) n_state = ST_DRAIN;
            end
            ST_MS: begin
                if (last_x && last_y && last_z) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drained) n_state = (r_mode == MODE_MEAN) ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_OUT;
            end
            ST_CLR: begin
                if (!r_clearing) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_o_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        issue     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        rd_addr   = cell_addr(r_px, r_py, r_wz);
        case (r_state)
            ST_COL:   issue = 1'b1;
            ST_MS: begin
                issue   = 1'b1;
                rd_addr = cell_addr(r_wx, r_wy, r_wz);
            end
            ST_DRAIN: div_start = drained && (r_mode == MODE_MEAN);
            ST_OUT:   out_load  = !r_o_valid || i_out_ready;
            default: begin
                issue = 1'b0;
            end
        endcase
        if (r_clearing) begin
            wr.en   = 1'b1;
            wr.addr = r_clr_addr;
            wr.data = '0;
        end else begin
            wr.en   = in_acc && (in_mode == MODE_WRITE) && !bad_xy && !bad_z;
            wr.addr = cell_addr(X_W'(i_pos_x), Y_W'(i_pos_y), Z_W'(i_pos_z));
            wr.data = sat_in(i_voxel_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_dim_x    <= DIM_RESET;
            r_dim_y    <= DIM_RESET;
            r_dim_z    <= DIM_RESET;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_sq_vld   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r_sq_vld <= r_rd_vld && (r_mode == MODE_MEAN);
            if (cfg_acc) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DIM_X: r_dim_x <= i_cfg_data;
                    CFG_DIM_Y: r_dim_y <= i_cfg_data;
                    CFG_DIM_Z: r_dim_z <= i_cfg_data;
                    default:   r_dim_x <= r_dim_x;
                endcase
            end
            if (clr_start) begin
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == t_addr'(CELL_COUNT - 1)) r_clearing <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= in_mode;
            r_px     <= X_W'(i_pos_x);
            r_py     <= Y_W'(i_pos_y);
            r_wx     <= '0;
            r_wy     <= '0;
            r_wz     <= '0;
            r_sum    <= '0;
            case (in_mode)
                MODE_WRITE:  r_status <= bad_xy || bad_z;
                MODE_COLUMN: r_status <= bad_xy;
                default:     r_status <= 1'b0;
            endcase
        end else begin
            if (issue) begin
                if (r_state == ST_COL || (last_x && last_y)) begin
                    r_wz <= r_wz + 1'b1;
                end
                if (r_state == ST_MS) begin
                    r_wx <= last_x ? '0 : r_wx + 1'b1;
                    if (last_x) r_wy <= last_y ? '0 : r_wy + 1'b1;
                end
            end
            if (r_sq_vld) begin
                r_sum <= acc[SUM_W] ? '1 : acc[SUM_W-1:0];
            end
        end
        r_rd_z <= r_wz;
        r_sq   <= mag * mag;
        if (r_rd_vld && r_mode == MODE_COLUMN) begin
            if (r_rd_z == '0 || rdata > r_best) begin
                r_best <= rdata;
                r_at   <= r_rd_z;
            end
        end
        if (out_load) begin
            r_o_status <= r_status;
            case (r_mode)
                MODE_COLUMN: begin
                    r_o_score <= r_status ? '0 : sat_out(r_best);
                    r_o_layer <= r_status ? '0 : LAYER_W'(r_at);
                    r_o_mean  <= '0;
                end
                MODE_MEAN: begin
                    r_o_score <= '0;
                    r_o_layer <= '0;
                    r_o_mean  <= (|quotient[SUM_W-1:MEAN_W]) ? '1 : quotient[MEAN_W-1:0];
                end
                default: begin
                    r_o_score <= '0;
                    r_o_layer <= '0;
                    r_o_mean  <= '0;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE) && !r_clearing;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_o_valid;
    assign o_max_score   = r_o_score;
    assign o_max_layer   = r_o_layer;
    assign o_mean_square = r_o_mean;
    assign o_status      = r_o_status;

endmodule
